// ===== hdl/ccs_pkg.sv =====
// Package for the calendar clock step block: payload types, op codes and calendar helpers.
`timescale 1ns / 1ps

package ccs_pkg;

  // Request operation codes.
  typedef enum logic [2:0] {
    OP_SEC_FWD  = 3'd0,
    OP_SEC_BACK = 3'd1,
    OP_DAY_FWD  = 3'd2,
    OP_DAY_BACK = 3'd3,
    OP_LOAD     = 3'd4
  } op_t;

  // Input request payload.
  typedef struct packed {
    op_t        op;
    logic [5:0] load_second;
    logic [5:0] load_minute;
    logic [4:0] load_hour;
    logic [8:0] load_yday;
    logic [2:0] load_wday;
    logic [9:0] load_year;
  } in_item_t;

  // Result payload.
  typedef struct packed {
    logic [5:0] second_out;
    logic [5:0] minute_out;
    logic [4:0] hour_out;
    logic [3:0] month_out;
    logic [4:0] mday_out;
    logic [8:0] yday_out;
    logic [2:0] wday_out;
    logic [9:0] year_out;
    logic       is_am;
    logic [3:0] hour_twelve;
  } out_item_t;

  // Field limits.
  localparam logic [5:0] SEC_MAX          = 6'd59;
  localparam logic [5:0] MIN_MAX          = 6'd59;
  localparam logic [4:0] HOUR_MAX         = 5'd23;
  localparam logic [4:0] HOUR_NOON        = 5'd12;
  localparam logic [3:0] HOUR_TWELVE      = 4'd12;
  localparam logic [2:0] WDAY_MAX         = 3'd6;
  localparam logic [8:0] YDAY_LAST_COMMON = 9'd364;
  localparam logic [8:0] YDAY_LAST_LEAP   = 9'd365;
  localparam logic [3:0] MONTH_COUNT      = 4'd12;

  // Full-year arithmetic is wide enough for any supported year counter width.
  localparam int unsigned YEAR_CALC_W = 17;
  localparam int unsigned BASE_YEAR   = 1900;

  // Exact test for divisibility by 25 on 16-bit values: multiply by the
  // inverse of 25 modulo 2^16 and compare against floor((2^16 - 1) / 25).
  localparam logic [15:0] INV25       = 16'd23593;
  localparam logic [15:0] DIV25_LIMIT = 16'd2621;

  // Gregorian leap rule on the year counted from 1900.
  function automatic logic is_leap(input logic [YEAR_CALC_W-1:0] yc_ext);
    logic [YEAR_CALC_W-1:0] y;
    logic [15:0]            q;
    logic [15:0]            prod;
    logic                   div4;
    logic                   div16;
    logic                   div100;
    y      = yc_ext + YEAR_CALC_W'(BASE_YEAR);
    div4   = (y[1:0] == 2'd0);
    div16  = (y[3:0] == 4'd0);
    q      = 16'(y >> 2);
    prod   = 16'(q * INV25);
    div100 = div4 && (prod <= DIV25_LIMIT);
    return div4 && (!div100 || div16);
  endfunction

  // Last zero-based day of the year.
  function automatic logic [8:0] last_day(input logic leap);
    return leap ? YDAY_LAST_LEAP : YDAY_LAST_COMMON;
  endfunction

  // Zero-based day of year on which a month starts.
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    unique case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + ((leap && (m >= 4'd2)) ? 9'd1 : 9'd0);
  endfunction

endpackage

// ===== hdl/calendar_clock_step.sv =====
// Top level of the calendar clock: input register, step logic, result register.
`timescale 1ns / 1ps

// Calendar clock step.
// The input channel (in_valid, in_ready, in_data) carries one request per
// accepted item: step one second forward or back, step one day forward or
// back, or load a full time. The result channel (out_valid, out_ready,
// out_data) returns exactly one result per request: the time after the step,
// with month, day of month, AM flag and 12-hour hour derived from it.
// A request is captured in an input register; the step is then computed from
// that register, and the new time is written to the state and to the result
// register once the result register can advance. out_valid rises as the
// result is written, and a new request can be accepted every cycle while the
// receiver keeps taking results. The step path is one carry chain, one
// constant multiply for the leap test and eleven month-start compares.
// When the receiver stalls, one more request is still taken into the input
// register; after that in_ready drops until the result is taken.
// Synchronous reset sets 00:00:00, Monday, day 0 of 1900 and empties both
// registers; no clearing pass is needed.
module calendar_clock_step #(
  parameter int unsigned YEAR_BITS = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ccs_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ccs_pkg::out_item_t  out_data
);

  localparam int unsigned YW = ccs_pkg::YEAR_CALC_W;

  // Handshake and pipeline registers.
  logic               in_valid_r;
  ccs_pkg::in_item_t  in_r;
  logic               out_valid_r;
  ccs_pkg::out_item_t out_r;
  logic               advance;
  logic               step_en;

  // Calendar state.
  logic [5:0]           sec_r,  sec_nxt;
  logic [5:0]           min_r,  min_nxt;
  logic [4:0]           hour_r, hour_nxt;
  logic [8:0]           yday_r, yday_nxt;
  logic [2:0]           wday_r, wday_nxt;
  logic [YEAR_BITS-1:0] year_r, year_nxt;
  logic                 leap_r, leap_nxt;

  // Step intermediates.
  logic                 day_fwd;
  logic                 day_back;
  logic                 year_wrap_up;
  logic                 year_wrap_down;
  logic [YW-1:0]        load_year_ext;
  logic [YW-1:0]        year_out_ext;
  logic [3:0]           month_nxt;
  logic [4:0]           mday_nxt;
  logic [4:0]           h12_base;
  logic [3:0]           h12;
  ccs_pkg::out_item_t   out_nxt;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !in_valid_r || advance;
  assign step_en   = in_valid_r && advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Input register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // Second, minute, hour and weekday update; decide on day carries.
  always_comb begin
    sec_nxt  = sec_r;
    min_nxt  = min_r;
    hour_nxt = hour_r;
    wday_nxt = wday_r;
    day_fwd  = 1'b0;
    day_back = 1'b0;
    unique case (in_r.op)
      ccs_pkg::OP_SEC_FWD: begin
        if (sec_r < ccs_pkg::SEC_MAX) begin
          sec_nxt = sec_r + 6'd1;
        end else begin
          sec_nxt = 6'd0;
          if (min_r < ccs_pkg::MIN_MAX) begin
            min_nxt = min_r + 6'd1;
          end else begin
            min_nxt = 6'd0;
            if (hour_r < ccs_pkg::HOUR_MAX) begin
              hour_nxt = hour_r + 5'd1;
            end else begin
              hour_nxt = 5'd0;
              day_fwd  = 1'b1;
            end
          end
        end
      end
      ccs_pkg::OP_SEC_BACK: begin
        if (sec_r != 6'd0) begin
          sec_nxt = sec_r - 6'd1;
        end else begin
          sec_nxt = ccs_pkg::SEC_MAX;
          if (min_r != 6'd0) begin
            min_nxt = min_r - 6'd1;
          end else begin
            min_nxt = ccs_pkg::MIN_MAX;
            if (hour_r != 5'd0) begin
              hour_nxt = hour_r - 5'd1;
            end else begin
              hour_nxt = ccs_pkg::HOUR_MAX;
              day_back = 1'b1;
            end
          end
        end
      end
      ccs_pkg::OP_DAY_FWD: begin
        day_fwd = 1'b1;
      end
      ccs_pkg::OP_DAY_BACK: begin
        day_back = 1'b1;
      end
      ccs_pkg::OP_LOAD: begin
        sec_nxt  = (in_r.load_second > ccs_pkg::SEC_MAX) ? ccs_pkg::SEC_MAX
                                                         : in_r.load_second;
        min_nxt  = (in_r.load_minute > ccs_pkg::MIN_MAX) ? ccs_pkg::MIN_MAX
                                                         : in_r.load_minute;
        hour_nxt = (in_r.load_hour > ccs_pkg::HOUR_MAX) ? ccs_pkg::HOUR_MAX
                                                        : in_r.load_hour;
        wday_nxt = (in_r.load_wday > ccs_pkg::WDAY_MAX) ? ccs_pkg::WDAY_MAX
                                                        : in_r.load_wday;
      end
      default: begin
        // Unused codes leave the time as it is.
      end
    endcase
    if (day_fwd) begin
      wday_nxt = (wday_r == ccs_pkg::WDAY_MAX) ? 3'd0 : wday_r + 3'd1;
    end else if (day_back) begin
      wday_nxt = (wday_r == 3'd0) ? ccs_pkg::WDAY_MAX : wday_r - 3'd1;
    end
  end

  // Year update and the leap flag of the resulting year.
  assign year_wrap_up   = day_fwd && (yday_r >= ccs_pkg::last_day(leap_r));
  assign year_wrap_down = day_back && (yday_r == 9'd0);
  assign load_year_ext  = YW'(in_r.load_year);

  always_comb begin
    year_nxt = year_r;
    if (in_r.op == ccs_pkg::OP_LOAD) begin
      year_nxt = load_year_ext[YEAR_BITS-1:0];
    end else if (year_wrap_up) begin
      year_nxt = YEAR_BITS'(year_r + 1'b1);
    end else if (year_wrap_down) begin
      year_nxt = YEAR_BITS'(year_r - 1'b1);
    end
  end

  assign leap_nxt = ccs_pkg::is_leap(YW'(year_nxt));

  // Day of year update.
  always_comb begin
    yday_nxt = yday_r;
    if (in_r.op == ccs_pkg::OP_LOAD) begin
      yday_nxt = (in_r.load_yday > ccs_pkg::last_day(leap_nxt)) ?
                 ccs_pkg::last_day(leap_nxt) : in_r.load_yday;
    end else if (day_fwd) begin
      yday_nxt = year_wrap_up ? 9'd0 : yday_r + 9'd1;
    end else if (day_back) begin
      yday_nxt = year_wrap_down ? ccs_pkg::last_day(leap_nxt) : yday_r - 9'd1;
    end
  end

  // Month and day of month from the day of year; the last month started wins.
  always_comb begin
    month_nxt = 4'd0;
    for (int k = 1; k < int'(ccs_pkg::MONTH_COUNT); k++) begin
      if (yday_nxt >= ccs_pkg::month_start(4'(k), leap_nxt)) begin
        month_nxt = 4'(k);
      end
    end
    mday_nxt = 5'(yday_nxt - ccs_pkg::month_start(month_nxt, leap_nxt) + 9'd1);
  end

  // 12-hour presentation.
  assign h12_base = (hour_nxt >= ccs_pkg::HOUR_NOON) ? hour_nxt - ccs_pkg::HOUR_NOON
                                                     : hour_nxt;
  assign h12      = (h12_base == 5'd0) ? ccs_pkg::HOUR_TWELVE : h12_base[3:0];

  // Result assembly.
  assign year_out_ext = YW'(year_nxt);

  always_comb begin
    out_nxt.second_out  = sec_nxt;
    out_nxt.minute_out  = min_nxt;
    out_nxt.hour_out    = hour_nxt;
    out_nxt.month_out   = month_nxt;
    out_nxt.mday_out    = mday_nxt;
    out_nxt.yday_out    = yday_nxt;
    out_nxt.wday_out    = wday_nxt;
    out_nxt.year_out    = year_out_ext[9:0];
    out_nxt.is_am       = (hour_nxt < ccs_pkg::HOUR_NOON);
    out_nxt.hour_twelve = h12;
  end

  // Calendar state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r  <= 6'd0;
      min_r  <= 6'd0;
      hour_r <= 5'd0;
      yday_r <= 9'd0;
      wday_r <= 3'd1;
      year_r <= '0;
      leap_r <= 1'b0;
    end else if (step_en) begin
      sec_r  <= sec_nxt;
      min_r  <= min_nxt;
      hour_r <= hour_nxt;
      yday_r <= yday_nxt;
      wday_r <= wday_nxt;
      year_r <= year_nxt;
      leap_r <= leap_nxt;
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (step_en) begin
      out_r <= out_nxt;
    end
  end

`ifndef SYNTHESIS
  // The stored leap flag always matches the stored year.
  a_leap_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    leap_r == ccs_pkg::is_leap(YW'(year_r)))
    else $error("leap flag does not match the year");

  // The day of year never passes the last day of its year.
  a_yday_range: assert property (@(posedge clk) disable iff (!rst_n)
    yday_r <= ccs_pkg::last_day(leap_r))
    else $error("day of year beyond the last day");

  // Time of day and weekday stay in range.
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sec_r <= ccs_pkg::SEC_MAX) && (min_r <= ccs_pkg::MIN_MAX) &&
    (hour_r <= ccs_pkg::HOUR_MAX) && (wday_r <= ccs_pkg::WDAY_MAX))
    else $error("time of day or weekday out of range");

  // A request held in the input register during a stall is kept for the next cycle.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_r))
    else $error("stalled request lost from the input register");
`endif

endmodule

// ===== dv/tb_calendar_clock_step.sv =====
// Self-checking testbench for the calendar clock step block.
`timescale 1ns / 1ps

module tb_calendar_clock_step;
  import ccs_pkg::*;

  localparam int unsigned YEAR_BITS    = 10;
  localparam int unsigned RANDOM_COUNT = 500;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // Op codes that the block must treat as no operation.
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  // Cumulative days before each month in a common year.
  localparam int unsigned MONTH_FIRST [12] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  // Values near the calendar boundaries, used to force carries.
  localparam int unsigned YDAY_EDGES [6] = '{0, 58, 59, 60, 364, 365};
  localparam int unsigned YEAR_EDGES [8] = '{0, 99, 100, 103, 104, 199, 200, 1023};

  // Tracks the calendar time the block should hold and checks its results.
  class calendar_tracker;
    logic [5:0]           second_now;
    logic [5:0]           minute_now;
    logic [4:0]           hour_now;
    logic [8:0]           yday_now;
    logic [2:0]           wday_now;
    logic [YEAR_BITS-1:0] year_now;
    logic [3:0]           month_now;
    logic [4:0]           mday_now;
    out_item_t            expected_times [$];
    int unsigned          failures;

    function new();
      second_now = '0;
      minute_now = '0;
      hour_now   = '0;
      yday_now   = '0;
      wday_now   = 3'd1;
      year_now   = '0;
      month_now  = '0;
      mday_now   = 5'd1;
      failures   = 0;
    endfunction

    // Gregorian rule on the year counted from 1900.
    function bit leap_year_of(logic [YEAR_BITS-1:0] years_since);
      int unsigned y;
      y = years_since + 1900;
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function logic [8:0] last_day_of(logic [YEAR_BITS-1:0] years_since);
      return leap_year_of(years_since) ? 9'd365 : 9'd364;
    endfunction

    function int unsigned month_first_day(int unsigned m, bit leap);
      return MONTH_FIRST[m] + ((leap && m >= 2) ? 1 : 0);
    endfunction

    // Month and day of month follow from the day of year.
    function void derive_month();
      bit leap;
      leap = leap_year_of(year_now);
      month_now = '0;
      for (int k = 1; k < 12; k++) begin
        if (yday_now >= month_first_day(k, leap)) month_now = 4'(k);
      end
      mday_now = 5'(yday_now - month_first_day(month_now, leap) + 1);
    endfunction

    function void day_forward();
      wday_now = 3'((wday_now + 1) % 7);
      if (yday_now >= last_day_of(year_now)) begin
        yday_now = '0;
        year_now = year_now + 1'b1;
      end else begin
        yday_now = yday_now + 1'b1;
      end
      derive_month();
    endfunction

    function void day_back();
      wday_now = (wday_now == 3'd0) ? 3'd6 : wday_now - 1'b1;
      if (yday_now == 9'd0) begin
        year_now = year_now - 1'b1;
        yday_now = last_day_of(year_now);
      end else begin
        yday_now = yday_now - 1'b1;
      end
      derive_month();
    endfunction

    // Apply one accepted request and queue the time it should produce.
    function void note_request(in_item_t req);
      out_item_t want;
      logic [3:0] h12;
      case (req.op)
        OP_SEC_FWD: begin
          if (second_now < SEC_MAX) second_now = second_now + 1'b1;
          else begin
            second_now = '0;
            if (minute_now < MIN_MAX) minute_now = minute_now + 1'b1;
            else begin
              minute_now = '0;
              if (hour_now < HOUR_MAX) hour_now = hour_now + 1'b1;
              else begin
                hour_now = '0;
                day_forward();
              end
            end
          end
        end
        OP_SEC_BACK: begin
          if (second_now > 0) second_now = second_now - 1'b1;
          else begin
            second_now = SEC_MAX;
            if (minute_now > 0) minute_now = minute_now - 1'b1;
            else begin
              minute_now = MIN_MAX;
              if (hour_now > 0) hour_now = hour_now - 1'b1;
              else begin
                hour_now = HOUR_MAX;
                day_back();
              end
            end
          end
        end
        OP_DAY_FWD: day_forward();
        OP_DAY_BACK: day_back();
        OP_LOAD: begin
          second_now = (req.load_second > SEC_MAX) ? SEC_MAX : req.load_second;
          minute_now = (req.load_minute > MIN_MAX) ? MIN_MAX : req.load_minute;
          hour_now   = (req.load_hour > HOUR_MAX) ? HOUR_MAX : req.load_hour;
          year_now   = YEAR_BITS'(req.load_year);
          yday_now   = (req.load_yday > last_day_of(year_now)) ?
                       last_day_of(year_now) : req.load_yday;
          wday_now   = (req.load_wday > WDAY_MAX) ? WDAY_MAX : req.load_wday;
          derive_month();
        end
        default: begin
          // Spare codes leave the time as it is.
        end
      endcase

      h12 = 4'(hour_now % 12);
      if (h12 == 4'd0) h12 = HOUR_TWELVE;
      want.second_out  = second_now;
      want.minute_out  = minute_now;
      want.hour_out    = hour_now;
      want.month_out   = month_now;
      want.mday_out    = mday_now;
      want.yday_out    = yday_now;
      want.wday_out    = wday_now;
      want.year_out    = 10'(year_now);
      want.is_am       = (hour_now < HOUR_NOON);
      want.hour_twelve = h12;
      expected_times.push_back(want);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s expected %0d actual %0d", field, want, got);
        failures++;
      end
    endfunction

    // Compare one accepted result with the oldest queued time.
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_times.size() == 0) begin
        $error("result arrived with no request outstanding");
        failures++;
        return;
      end
      want = expected_times.pop_front();
      compare_field("second_out", want.second_out, got.second_out);
      compare_field("minute_out", want.minute_out, got.minute_out);
      compare_field("hour_out", want.hour_out, got.hour_out);
      compare_field("month_out", want.month_out, got.month_out);
      compare_field("mday_out", want.mday_out, got.mday_out);
      compare_field("yday_out", want.yday_out, got.yday_out);
      compare_field("wday_out", want.wday_out, got.wday_out);
      compare_field("year_out", want.year_out, got.year_out);
      compare_field("is_am", want.is_am, got.is_am);
      compare_field("hour_twelve", want.hour_twelve, got.hour_twelve);
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  calendar_tracker tracker = new();
  int unsigned     cycle_count = 0;
  int unsigned     send_left = 0;
  bit              send_quiet = 1'b0;
  int unsigned     recv_left = 0;
  bit              recv_quiet = 1'b0;

  calendar_clock_step #(
    .YEAR_BITS(YEAR_BITS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Idle cycles before the next handshake; now and then a stretch runs with none.
  function automatic int unsigned next_wait(inout int unsigned left, inout bit quiet);
    if (left == 0) begin
      quiet = ($urandom_range(3, 0) == 0);
      left  = $urandom_range(40, 10);
    end
    left--;
    return quiet ? 0 : $urandom_range(15, 0);
  endfunction

  function automatic in_item_t make_step(logic [2:0] code);
    in_item_t req;
    req    = '0;
    req.op = op_t'(code);
    return req;
  endfunction

  function automatic in_item_t make_load(int unsigned sec, int unsigned min,
                                         int unsigned hr, int unsigned yday,
                                         int unsigned wday, int unsigned year);
    in_item_t req;
    req.op          = OP_LOAD;
    req.load_second = 6'(sec);
    req.load_minute = 6'(min);
    req.load_hour   = 5'(hr);
    req.load_yday   = 9'(yday);
    req.load_wday   = 3'(wday);
    req.load_year   = 10'(year);
    return req;
  endfunction

  // Present one request after a random gap and hold it until accepted.
  task automatic drive_request(input in_item_t req);
    int unsigned gap;
    gap = next_wait(send_left, send_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(req);
  endtask

  // Result side: stall at random, then check every accepted result.
  initial begin
    int unsigned stall;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = next_wait(recv_left, recv_quiet);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      tracker.check_result(out_data);
    end
  end

  // Reset, directed requests, random requests, then drain and report.
  initial begin
    in_item_t    req;
    int unsigned pick;
    int unsigned shape;

    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Borrow from midnight of the first day wraps the year counter down,
    // and the carry back wraps it up again.
    drive_request(make_step(OP_SEC_BACK));
    drive_request(make_step(OP_SEC_FWD));
    for (int code = OP_SPARE_FIRST; code <= OP_SPARE_LAST; code++) begin
      drive_request(make_step(3'(code)));
    end
    // Every load field above its range saturates; day of year is clamped.
    drive_request(make_load(63, 63, 31, 511, 7, 1023));
    // Last second of a leap year divisible by 400, then across the new year.
    drive_request(make_load(59, 59, 23, 365, 6, 100));
    drive_request(make_step(OP_SEC_FWD));
    drive_request(make_step(OP_SEC_BACK));
    // A century year that is not leap clamps day 365 to 364.
    drive_request(make_load(0, 0, 0, 365, 3, 0));
    drive_request(make_step(OP_DAY_FWD));
    drive_request(make_load(30, 30, 12, 59, 2, 200));
    // Leap day, then across the end of February both ways.
    drive_request(make_load(0, 0, 11, 59, 4, 104));
    drive_request(make_step(OP_DAY_FWD));
    drive_request(make_step(OP_DAY_BACK));
    drive_request(make_step(OP_DAY_BACK));
    // Day steps across the year counter wrap.
    drive_request(make_load(0, 0, 0, 0, 0, 0));
    drive_request(make_step(OP_DAY_BACK));
    drive_request(make_step(OP_DAY_FWD));
    drive_request(make_load(5, 5, 13, 334, 1, 123));
    drive_request(make_load(0, 0, 0, 31, 0, 125));

    // Random requests: mostly steps, with loads that often land near a carry.
    for (int i = 0; i < RANDOM_COUNT; i++) begin
      req.load_second = 6'($urandom);
      req.load_minute = 6'($urandom);
      req.load_hour   = 5'($urandom);
      req.load_yday   = 9'($urandom);
      req.load_wday   = 3'($urandom);
      req.load_year   = 10'($urandom);
      pick = $urandom_range(99, 0);
      if (pick < 35) req.op = OP_SEC_FWD;
      else if (pick < 55) req.op = OP_SEC_BACK;
      else if (pick < 70) req.op = OP_DAY_FWD;
      else if (pick < 80) req.op = OP_DAY_BACK;
      else if (pick < 95) req.op = OP_LOAD;
      else req.op = op_t'(3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)));

      if (req.op == OP_LOAD) begin
        shape = $urandom_range(2, 0);
        if (shape == 1) begin
          req.load_second = 6'($urandom_range(59, 0));
          req.load_minute = 6'($urandom_range(59, 0));
          req.load_hour   = 5'($urandom_range(23, 0));
          req.load_yday   = 9'($urandom_range(365, 0));
          req.load_wday   = 3'($urandom_range(6, 0));
        end else if (shape == 2) begin
          req.load_second = $urandom_range(1, 0) ? SEC_MAX : 6'd0;
          req.load_minute = $urandom_range(1, 0) ? MIN_MAX : 6'd0;
          req.load_hour   = $urandom_range(1, 0) ? HOUR_MAX : 5'd0;
          req.load_yday   = 9'(YDAY_EDGES[$urandom_range(5, 0)]);
          req.load_wday   = 3'($urandom_range(6, 0));
          req.load_year   = 10'(YEAR_EDGES[$urandom_range(7, 0)]);
        end
      end
      drive_request(req);
    end
    in_valid <= 1'b0;

    // Wait for every outstanding result, then watch for stray ones.
    while (tracker.expected_times.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
